// ===== src/hoare_quicksort_swap_count_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for hoare_quicksort_swap_count_core
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef HOARE_QUICKSORT_SWAP_COUNT_CORE_ASSERT_SVH
`define HOARE_QUICKSORT_SWAP_COUNT_CORE_ASSERT_SVH

// same-cycle implication
`define HQS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HQS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/hqs_pkg.sv =====
// ----------------------------------------------------------------------------
// hqs_pkg
// Shared widths and types of the quicksort swap-count core.
// ----------------------------------------------------------------------------
package hqs_pkg;

	localparam int CAPACITY    = 64;
	localparam int DATA_WIDTH  = 32;
	localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int RNG_W       = 6;
	localparam int STACK_DEPTH = 64;
	localparam int STK_IDX_W   = $clog2(STACK_DEPTH);
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int SWAP_W      = 12;
	localparam int IN_TDATA_W  = 8 * ((DATA_WIDTH + 7) / 8);
	localparam int OUT_BITS    = DATA_WIDTH + SWAP_W;
	localparam int OUT_TDATA_W = 8 * ((OUT_BITS + 7) / 8);
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;

	localparam logic [SWAP_W-1:0] SWAP_MAX = {SWAP_W{1'b1}};

	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [SP_W-1:0]        sp_t;
	typedef logic [DATA_WIDTH-1:0]  word_t;
	typedef logic [2*RNG_W-1:0]     range_t;

endpackage

// ===== src/hoare_quicksort_swap_count_core.sv =====
// ----------------------------------------------------------------------------
// hoare_quicksort_swap_count_core
// Collects a set of signed values, quicksorts it in place and streams the
// sorted set out with the number of swaps the sort made.
// ----------------------------------------------------------------------------
// Values arrive one per transfer on the slave side until tlast; the set then
// holds up to 64 values, further ones are dropped and flagged as overflow.
// Loading takes one value per cycle. The sort runs Hoare partitions with the
// middle element as pivot over a range stack; each scan step reads element
// memory, then compares; each swap writes its two elements in turn through the
// one write port; each partition pops its range and reads its pivot first.
// Each output value is read from memory, registered and held until taken.
// Overall rate is bound by the element memory ports. No input is taken from
// the start of sorting until the last sorted value is transferred.
`include "hoare_quicksort_swap_count_core_assert.svh"

module hoare_quicksort_swap_count_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [hqs_pkg::IN_TDATA_W-1:0]  s_tdata,   // value
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [hqs_pkg::OUT_TDATA_W-1:0] m_tdata,   // sorted_value, swap_count, zero pad
	output logic                            m_tuser,   // overflow
	output logic                            m_tlast
);
	import hqs_pkg::*;

	localparam logic [3:0] ST_LOAD     = 4'd0;
	localparam logic [3:0] ST_START    = 4'd1;
	localparam logic [3:0] ST_POP      = 4'd2;
	localparam logic [3:0] ST_POP_WAIT = 4'd3;
	localparam logic [3:0] ST_PIV_WAIT = 4'd4;
	localparam logic [3:0] ST_SCAN_RD  = 4'd5;
	localparam logic [3:0] ST_CMP      = 4'd6;
	localparam logic [3:0] ST_SWAP2    = 4'd7;
	localparam logic [3:0] ST_PUSH1    = 4'd8;
	localparam logic [3:0] ST_PUSH2    = 4'd9;
	localparam logic [3:0] ST_OUT_RD   = 4'd10;
	localparam logic [3:0] ST_OUT_WAIT = 4'd11;
	localparam logic [3:0] ST_OUT_HOLD = 4'd12;

	word_t  elem_mem [CAPACITY];
	range_t stk_mem  [STACK_DEPTH];

	logic [3:0]          state_q;
	cnt_t                count_q;
	sp_t                 sp_q;
	logic [SWAP_W-1:0]   swap_q;
	logic                ovf_q;
	idx_t                lo_q, hi_q, i_q, j_q, q_q, k_q;
	word_t               pivot_q, tmp_q, m_val_q;
	logic                m_valid_q, m_last_q;

	word_t               rd_a_q, rd_b_q;
	range_t              stk_rd_q;
	idx_t                addr_a;
	logic                el_we;
	idx_t                el_wa;
	word_t               el_wd;
	logic                stk_we;
	logic [STK_IDX_W-1:0] stk_wa, stk_ra;
	range_t              stk_wd;
	sp_t                 sp_m1;
	idx_t                pop_lo, pop_hi, pop_mid;
	logic [IDX_W:0]      mid_sum;
	logic                i_go, j_go, in_xfer, sp_room;
	cnt_t                count_m1;

	assign s_tready = (state_q == ST_LOAD);
	assign in_xfer  = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, swap_q, m_val_q};
	assign m_tuser  = ovf_q;
	assign m_tlast  = m_last_q;

	assign sp_m1    = sp_q - SP_W'(1);
	assign stk_ra   = sp_m1[STK_IDX_W-1:0];
	assign sp_room  = (sp_q < SP_W'(STACK_DEPTH));
	assign pop_lo   = stk_rd_q[RNG_W +: IDX_W];
	assign pop_hi   = stk_rd_q[IDX_W-1:0];
	assign mid_sum  = {1'b0, pop_lo} + {1'b0, pop_hi};
	assign pop_mid  = mid_sum[IDX_W:1];
	assign count_m1 = count_q - CNT_W'(1);

	assign i_go = (i_q < hi_q) && ($signed(rd_a_q) < $signed(pivot_q));
	assign j_go = (j_q > lo_q) && ($signed(rd_b_q) > $signed(pivot_q));

	always_comb begin
		case (state_q)
			ST_POP_WAIT: addr_a = pop_mid;
			ST_OUT_RD:   addr_a = k_q;
			default:     addr_a = i_q;
		endcase
	end

	always_comb begin
		el_we = 1'b0;
		el_wa = i_q;
		el_wd = rd_b_q;
		unique case (state_q)
			ST_LOAD: begin
				el_we = in_xfer && (count_q < CNT_W'(CAPACITY));
				el_wa = count_q[IDX_W-1:0];
				el_wd = s_tdata[DATA_WIDTH-1:0];
			end
			ST_CMP: begin
				el_we = !i_go && !j_go && (i_q < j_q);
			end
			ST_SWAP2: begin
				el_we = 1'b1;
				el_wa = j_q;
				el_wd = tmp_q;
			end
			default: el_we = 1'b0;
		endcase
	end

	always_comb begin
		stk_we = 1'b0;
		stk_wa = sp_q[STK_IDX_W-1:0];
		stk_wd = {RNG_W'(lo_q), RNG_W'(q_q)};
		unique case (state_q)
			ST_START: begin
				stk_we = (count_q >= CNT_W'(2));
				stk_wa = '0;
				stk_wd = {RNG_W'(0), RNG_W'(count_m1)};
			end
			ST_PUSH1: begin
				stk_we = sp_room && (({1'b0, q_q} + (IDX_W+1)'(1)) < {1'b0, hi_q});
				stk_wd = {RNG_W'(q_q + IDX_W'(1)), RNG_W'(hi_q)};
			end
			ST_PUSH2: begin
				stk_we = sp_room && (lo_q < q_q);
			end
			default: stk_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (el_we) begin
			elem_mem[el_wa] <= el_wd;
		end
		rd_a_q <= elem_mem[addr_a];
		rd_b_q <= elem_mem[j_q];
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_wa] <= stk_wd;
		end
		stk_rd_q <= stk_mem[stk_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			sp_q      <= '0;
			swap_q    <= '0;
			ovf_q     <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_xfer) begin
						if (count_q < CNT_W'(CAPACITY)) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_tlast) begin
							state_q <= ST_START;
						end
					end
				end
				ST_START: begin
					k_q <= '0;
					if (count_q >= CNT_W'(2)) begin
						sp_q    <= SP_W'(1);
						state_q <= ST_POP;
					end else begin
						state_q <= ST_OUT_RD;
					end
				end
				ST_POP: begin
					if (sp_q == '0) begin
						k_q     <= '0;
						state_q <= ST_OUT_RD;
					end else begin
						sp_q    <= sp_m1;
						state_q <= ST_POP_WAIT;
					end
				end
				ST_POP_WAIT: begin
					if ((stk_rd_q[2*RNG_W-1:RNG_W] >= stk_rd_q[RNG_W-1:0]) ||
						(CNT_W'(stk_rd_q[RNG_W-1:0]) >= count_q)) begin
						state_q <= ST_POP;
					end else begin
						lo_q    <= pop_lo;
						hi_q    <= pop_hi;
						state_q <= ST_PIV_WAIT;
					end
				end
				ST_PIV_WAIT: begin
					pivot_q <= rd_a_q;
					i_q     <= lo_q;
					j_q     <= hi_q;
					state_q <= ST_SCAN_RD;
				end
				ST_SCAN_RD: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (i_go || j_go) begin
						if (i_go) begin
							i_q <= i_q + IDX_W'(1);
						end
						if (j_go) begin
							j_q <= j_q - IDX_W'(1);
						end
						state_q <= ST_SCAN_RD;
					end else if (i_q >= j_q) begin
						q_q     <= (j_q >= hi_q) ? (hi_q - IDX_W'(1)) : j_q;
						state_q <= ST_PUSH1;
					end else begin
						tmp_q   <= rd_a_q;
						state_q <= ST_SWAP2;
					end
				end
				ST_SWAP2: begin
					if (swap_q != SWAP_MAX) begin
						swap_q <= swap_q + SWAP_W'(1);
					end
					i_q <= i_q + IDX_W'(1);
					j_q <= j_q - IDX_W'(1);
					if (({1'b0, i_q} + (IDX_W+1)'(2)) <= {1'b0, j_q}) begin
						state_q <= ST_SCAN_RD;
					end else begin
						q_q     <= j_q - IDX_W'(1);
						state_q <= ST_PUSH1;
					end
				end
				ST_PUSH1: begin
					if (stk_we) begin
						sp_q <= sp_q + SP_W'(1);
					end
					state_q <= ST_PUSH2;
				end
				ST_PUSH2: begin
					if (stk_we) begin
						sp_q <= sp_q + SP_W'(1);
					end
					state_q <= ST_POP;
				end
				ST_OUT_RD: begin
					state_q <= ST_OUT_WAIT;
				end
				ST_OUT_WAIT: begin
					m_val_q   <= rd_a_q;
					m_last_q  <= ((CNT_W'(k_q) + CNT_W'(1)) == count_q);
					m_valid_q <= 1'b1;
					state_q   <= ST_OUT_HOLD;
				end
				ST_OUT_HOLD: begin
					if (m_tready) begin
						m_valid_q <= 1'b0;
						if (m_last_q) begin
							count_q <= '0;
							sp_q    <= '0;
							swap_q  <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							k_q     <= k_q + IDX_W'(1);
							state_q <= ST_OUT_RD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	`HQS_ASSERT_NOW(a_scan_in_range, state_q == ST_CMP,
		(i_q >= lo_q) && (i_q <= hi_q) && (j_q >= lo_q) && (j_q <= hi_q),
		"scan index left the partition range")
	`HQS_ASSERT_NOW(a_stack_bound, 1'b1, (sp_q <= SP_W'(STACK_DEPTH)) &&
		(count_q <= CNT_W'(CAPACITY)), "stack pointer or element count out of bounds")
	`HQS_ASSERT_NOW(a_sides_apart, 1'b1, !(s_tready && m_tvalid),
		"input accepted while a result is pending")
	`HQS_ASSERT_NEXT(a_swap_counted, (state_q == ST_SWAP2) && (swap_q != SWAP_MAX),
		swap_q == ($past(swap_q) + SWAP_W'(1)), "swap not counted")

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: quicksort swap-count core bench
// Streams data sets of signed values into the core, including extremes,
// duplicates, presorted runs, single values and sets beyond capacity. A
// built-in quicksort with middle-pivot Hoare partitions predicts every
// sorted value, the swap total, the overflow flag and the final marker.
// Both stream sides stall at random, with one calm window.
// ----------------------------------------------------------------------------
module tb;
	import hqs_pkg::*;

	typedef logic signed [DATA_WIDTH-1:0] sval_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] value;
		logic                  last;
	} in_item_t;

	typedef struct packed {
		sval_t             sorted_value;
		logic [SWAP_W-1:0] swap_count;
		logic              overflow;
		logic              final_res;
	} sorted_t;

	typedef enum int {
		MODE_WIDE,
		MODE_NARROW,
		MODE_EXTREME,
		MODE_FLAT,
		MODE_ASCENDING,
		MODE_DESCENDING
	} set_mode_t;

	localparam sval_t VAL_MIN      = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam sval_t VAL_MAX      = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam int    IDLE_PCT     = 18;
	localparam int    RANDOM_ITEMS = 270;
	localparam int    STALL_LIMIT  = 20000;
	localparam int    DRAIN_CYCLES = 50;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                   s_tlast  = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   m_tlast;

	in_item_t pending_items[$];
	sorted_t  sorted_expect[$];
	in_item_t next_item;
	sorted_t  got;
	sorted_t  want;

	sval_t held[CAPACITY];
	int    held_count    = 0;
	logic  held_overflow = 1'b0;
	int    swap_tally    = 0;

	logic s_taken        = 1'b0;
	int   accepted_items = 0;
	int   idle_cycles    = 0;
	int   errors         = 0;
	int   random_queued  = 0;
	logic calm;

	hoare_quicksort_swap_count_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	assign calm = (accepted_items >= 150) && (accepted_items < 260);

	function automatic int split_range(input int lo, input int hi);
		sval_t pivot;
		sval_t t;
		int    i;
		int    j;
		pivot = held[(lo + hi) >> 1];
		i = lo;
		j = hi;
		while (i <= j) begin
			while (i < hi && held[i] < pivot)
				i++;
			while (j > lo && held[j] > pivot)
				j--;
			if (i >= j)
				break;
			t = held[i];
			held[i] = held[j];
			held[j] = t;
			if (swap_tally < int'(SWAP_MAX))
				swap_tally++;
			i++;
			j--;
		end
		if (j < lo)
			j = lo;
		if (j >= hi)
			j = hi - 1;
		return j;
	endfunction

	task automatic take_value(input logic [DATA_WIDTH-1:0] value, input logic last);
		int      lo;
		int      hi;
		int      q;
		int      k;
		int      range_lo[$];
		int      range_hi[$];
		sorted_t r;
		if (held_count < CAPACITY) begin
			held[held_count] = value;
			held_count++;
		end else begin
			held_overflow = 1'b1;
		end
		if (last) begin
			swap_tally = 0;
			if (held_count >= 2) begin
				range_lo.push_back(0);
				range_hi.push_back(held_count - 1);
			end
			while (range_lo.size() != 0) begin
				lo = range_lo.pop_back();
				hi = range_hi.pop_back();
				q = split_range(lo, hi);
				if (q + 1 < hi) begin
					range_lo.push_back(q + 1);
					range_hi.push_back(hi);
				end
				if (lo < q) begin
					range_lo.push_back(lo);
					range_hi.push_back(q);
				end
			end
			for (k = 0; k < held_count; k++) begin
				r.sorted_value = held[k];
				r.swap_count   = swap_tally[SWAP_W-1:0];
				r.overflow     = held_overflow;
				r.final_res    = (k == held_count - 1);
				sorted_expect.push_back(r);
			end
			held_count    = 0;
			held_overflow = 1'b0;
		end
	endtask

	task automatic push_value(input sval_t v, input logic last);
		in_item_t it;
		it.value = v;
		it.last  = last;
		pending_items.push_back(it);
	endtask

	task automatic add_set(input int n, input set_mode_t mode);
		sval_t vals[$];
		sval_t v;
		int    k;
		for (k = 0; k < n; k++) begin
			case (mode)
				MODE_NARROW: v = sval_t'($urandom_range(7)) - 4;
				MODE_EXTREME: begin
					case ($urandom_range(4))
						0: v = VAL_MIN;
						1: v = VAL_MAX;
						2: v = '0;
						3: v = -1;
						default: v = $urandom;
					endcase
				end
				MODE_FLAT: v = (k == 0) ? sval_t'($urandom) : vals[0];
				default: v = $urandom;
			endcase
			vals.push_back(v);
		end
		if (mode == MODE_ASCENDING)
			vals.sort();
		else if (mode == MODE_DESCENDING)
			vals.rsort();
		for (k = 0; k < n; k++)
			push_value(vals[k], k == n - 1);
	endtask

	// driver: inputs change on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || s_taken) begin
				if (pending_items.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					next_item = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= next_item.value;
					s_tlast  <= next_item.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// monitor: sample on the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			s_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				take_value(s_tdata[DATA_WIDTH-1:0], s_tlast);
				accepted_items++;
			end
			if (m_tvalid && m_tready) begin
				got.sorted_value = m_tdata[DATA_WIDTH-1:0];
				got.swap_count   = m_tdata[DATA_WIDTH +: SWAP_W];
				got.overflow     = m_tuser;
				got.final_res    = m_tlast;
				if (sorted_expect.size() == 0) begin
					$display("%0t: unexpected transfer: value %0d swaps %0d ovf %0b last %0b",
						$time, got.sorted_value, got.swap_count, got.overflow,
						got.final_res);
					errors++;
				end else begin
					want = sorted_expect.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch: expected value %0d swaps %0d ovf %0b last %0b",
							$time, want.sorted_value, want.swap_count, want.overflow,
							want.final_res);
						$display("%0t:           actual   value %0d swaps %0d ovf %0b last %0b",
							$time, got.sorted_value, got.swap_count, got.overflow,
							got.final_res);
						errors++;
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
					$display("Test completed with failures");
					$finish;
				end
			end
		end
	end

	initial begin
		int r;
		int n;
		push_value(VAL_MIN, 1'b1);
		push_value(VAL_MAX, 1'b1);
		push_value(VAL_MAX, 1'b0);
		push_value(VAL_MIN, 1'b1);
		push_value(0, 1'b0);
		push_value(-1, 1'b0);
		push_value(1, 1'b0);
		push_value(VAL_MAX, 1'b0);
		push_value(VAL_MIN, 1'b1);
		add_set(4, MODE_FLAT);
		add_set(6, MODE_DESCENDING);
		add_set(CAPACITY, MODE_ASCENDING);
		add_set(CAPACITY + 3, MODE_WIDE);
		while (random_queued < RANDOM_ITEMS) begin
			r = $urandom_range(99);
			if (r < 70)
				n = $urandom_range(16, 1);
			else if (r < 92)
				n = $urandom_range(CAPACITY - 1, 17);
			else
				n = $urandom_range(CAPACITY + 4, CAPACITY);
			add_set(n, set_mode_t'($urandom_range(int'(MODE_DESCENDING))));
			random_queued += n;
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_items.size() != 0 || s_tvalid || sorted_expect.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/hqs_pkg.sv
src/hoare_quicksort_swap_count_core.sv
bench/tb.sv
